>>> sv/slt_pkg.sv
package slt_pkg;

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_SLASH   = 4'd1;
  localparam logic [3:0] M_COMMENT = 4'd2;
  localparam logic [3:0] M_OP      = 4'd3;
  localparam logic [3:0] M_IDENT   = 4'd4;
  localparam logic [3:0] M_NUMBER  = 4'd5;
  localparam logic [3:0] M_NUM_DOT = 4'd6;
  localparam logic [3:0] M_STRING  = 4'd7;
  localparam logic [3:0] M_ESCAPE  = 4'd8;

  localparam logic [5:0] K_STRLIT = 6'd20;
  localparam logic [5:0] K_DBLLIT = 6'd21;
  localparam logic [5:0] K_FLTLIT = 6'd22;
  localparam logic [5:0] K_LNGLIT = 6'd23;
  localparam logic [5:0] K_INTLIT = 6'd24;
  localparam logic [5:0] K_IDENT  = 6'd25;
  localparam logic [5:0] K_DOT    = 6'd33;
  localparam logic [5:0] K_SLASH  = 6'd40;
  localparam logic [5:0] K_EOF    = 6'd54;

  localparam logic [1:0] E_NONE     = 2'd0;
  localparam logic [1:0] E_UNTERM   = 2'd1;
  localparam logic [1:0] E_ESCAPE   = 2'd2;
  localparam logic [1:0] E_UNEXPECT = 2'd3;

  localparam int NumKeywords = 20;
  localparam int MaxResults  = 4;
  localparam int ResultWidth = 6 + 2 + 16 + 16 + 24 + 16 + 1;

  // One result word as it leaves the block.
  typedef struct packed {
    logic        last_result;
    logic [15:0] lexeme_length;
    logic [23:0] start_offset;
    logic [15:0] tok_column;
    logic [15:0] tok_line;
    logic [1:0]  error_code;
    logic [5:0]  token_kind;
  } result_t;

  // Up to four results caused by one byte, entries 0..count-1 valid.
  typedef struct packed {
    logic [2:0]               count;
    result_t [MaxResults-1:0] res;
  } bundle_t;

  // Keyword text, first character in the lowest byte, with its length.
  function automatic logic [63:0] kw_text(input int k);
    logic [63:0] t;
    t = '0;
    unique case (k)
      0:  t = 64'h6c6176;
      1:  t = 64'h726176;
      2:  t = 64'h666564;
      3:  t = 64'h6669;
      4:  t = 64'h65736c65;
      5:  t = 64'h656c696877;
      6:  t = 64'h726f66;
      7:  t = 64'h6e7275746572;
      8:  t = 64'h65757274;
      9:  t = 64'h65736c6166;
      10: t = 64'h64696f76;
      11: t = 64'h746375727473;
      12: t = 64'h6e6f696e75;
      13: t = 64'h6c706d69;
      14: t = 64'h746e69;
      15: t = 64'h676e6f6c;
      16: t = 64'h74616f6c66;
      17: t = 64'h656c62756f64;
      18: t = 64'h6c6f6f62;
      19: t = 64'h676e69727473;
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input int k);
    logic [3:0] n;
    unique case (k)
      3: n = 4'd2;
      0, 1, 2, 6, 14: n = 4'd3;
      4, 8, 10, 13, 15, 18: n = 4'd4;
      5, 9, 12, 16: n = 4'd5;
      default: n = 4'd6;
    endcase
    return n;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Kind of a one-character operator that pairs with nothing, or 0.
  function automatic logic [5:0] single_op(input logic [7:0] p);
    logic [5:0] k;
    unique case (p)
      "-": k = 6'd38;
      "&": k = 6'd43;
      "!": k = 6'd46;
      "=": k = 6'd48;
      "<": k = 6'd51;
      ">": k = 6'd53;
      default: k = 6'd0;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] double_op(input logic [7:0] p, input logic [7:0] c);
    logic [5:0] k;
    k = 6'd0;
    if (p == "-" && c == ">") k = 6'd37;
    else if (p == "&" && c == "&") k = 6'd42;
    else if (p == "|" && c == "|") k = 6'd44;
    else if (p == "!" && c == "=") k = 6'd45;
    else if (p == "=" && c == "=") k = 6'd47;
    else if (p == "<" && c == "=") k = 6'd49;
    else if (p == "<" && c == "-") k = 6'd50;
    else if (p == ">" && c == "=") k = 6'd52;
    return k;
  endfunction

  function automatic logic [5:0] punct_kind(input logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      "(": k = 6'd26;
      ")": k = 6'd27;
      "{": k = 6'd28;
      "}": k = 6'd29;
      ";": k = 6'd30;
      ",": k = 6'd31;
      ":": k = 6'd32;
      ".": k = 6'd33;
      "[": k = 6'd34;
      "]": k = 6'd35;
      "+": k = 6'd36;
      "*": k = 6'd39;
      "%": k = 6'd41;
      default: k = 6'd0;
    endcase
    return k;
  endfunction

endpackage

>>> sv/source_lexer_tokenizer.sv
// Streaming lexical scanner. One source byte is accepted per cycle on the
// slave stream; tlast marks the final byte of a source, which closes any
// pending token, emits a single EOF token unless an error was reported, and
// resets the scanner. Each byte may cause zero to four token words; these pass
// through a four-deep queue of per-byte bundles and leave on the master stream
// one word per cycle unless it stalls. A byte's words are registered in the
// queue and offered from its head. The input keeps taking one byte per cycle
// as long as the output keeps up; bytes that yield several words, or a stalled
// master stream, fill the queue, and once four bundles wait tready stays low,
// even in a cycle in which the head bundle leaves, until a slot is free again.
// After the first error word no more words come until the next source.
module source_lexer_tokenizer import slt_pkg::*; #(
  parameter int POSITION_WIDTH  = 16,
  parameter int OFFSET_WIDTH    = 24,
  parameter int KEYWORD_MAX_LEN = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // [7:0] src_byte
  input  logic                   s_axis_tlast,  // last_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [5:0] token_kind, [7:6] error_code, [23:8] tok_line, [39:24] tok_column,
  // [63:40] start_offset, [79:64] lexeme_length
  output logic [79:0]            m_axis_tdata,
  output logic                   m_axis_tlast   // last_result
);

  bundle_t    fr_bundle, q_bundle;
  logic       q_full, q_empty, q_pop, push, acc;
  logic [1:0] idx_q;
  result_t    cur;

  assign s_axis_tready = !q_full;
  assign acc  = s_axis_tvalid && s_axis_tready;
  assign push = acc && fr_bundle.count != 3'd0;

  slt_front #(
    .PosW (POSITION_WIDTH),
    .OffW (OFFSET_WIDTH),
    .KwMax(KEYWORD_MAX_LEN)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (acc),
    .c_i     (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .bundle_o(fr_bundle)
  );

  slt_queue #(.Depth(4)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (fr_bundle),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_bundle)
  );

  // Back end: walk the words of the head bundle, one per handshake.
  assign cur           = q_bundle.res[idx_q];
  assign m_axis_tvalid = !q_empty;
  assign m_axis_tdata  = {cur.lexeme_length, cur.start_offset, cur.tok_column,
                          cur.tok_line, cur.error_code, cur.token_kind};
  assign m_axis_tlast  = cur.last_result;
  assign q_pop = m_axis_tvalid && m_axis_tready && (3'(idx_q) + 3'd1 == q_bundle.count);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      idx_q <= q_pop ? 2'd0 : idx_q + 2'd1;
    end
  end

`ifndef ASSERT_OFF
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 3'(idx_q) < q_bundle.count) else $error("word index out of bundle");
  a_last_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (3'(idx_q) + 3'd1 == q_bundle.count)))
    else $error("tlast mismatch");
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty |-> idx_q == 2'd0) else $error("index not cleared");
`endif

endmodule

>>> sv/slt_front.sv
// Scanner front end: consumes one byte per cycle on which step_i is high and
// produces the bundle of results that byte causes.
module slt_front import slt_pkg::*; #(
  parameter int PosW = 16,
  parameter int OffW = 24,
  parameter int KwMax = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] c_i,
  input  logic       last_i,
  output bundle_t    bundle_o
);

  localparam logic [PosW-1:0] PosMax = '1;
  localparam logic [OffW-1:0] OffMax = '1;
  localparam int CharW = 8 * KwMax;

  logic [3:0]       mode_q, mode_d;
  logic [7:0]       pend_q, pend_d;
  logic [PosW-1:0]  line_q, line_d, col_q, col_d, sline_q, sline_d, scol_q, scol_d;
  logic [OffW-1:0]  off_q, off_d, spos_q, spos_d;
  logic [CharW-1:0] chars_q, chars_d;
  logic [15:0]      len_q, len_d;
  logic             frac_q, frac_d, halt_q, halt_d;

  // Keyword lookup on a candidate text and length.
  function automatic logic [5:0] ident_kind_next(input logic [CharW-1:0] ch,
                                                 input logic [15:0] ln);
    logic [5:0] r;
    r = K_IDENT;
    if (ln <= 16'(KwMax)) begin
      for (int k = NumKeywords - 1; k >= 0; k--) begin
        if (16'(kw_len(k)) == ln && kw_text(k) == 64'(ch)) r = 6'(k);
      end
    end
    return r;
  endfunction

  logic [5:0] kw_kind;
  always_comb begin
    logic [63:0] w;
    kw_kind = K_IDENT;
    w = 64'(chars_q);
    if (len_q <= 16'(KwMax)) begin
      for (int k = NumKeywords - 1; k >= 0; k--) begin
        if (16'(kw_len(k)) == len_q && kw_text(k) == w) kw_kind = 6'(k);
      end
    end
  end

  always_comb begin
    logic [2:0] n;
    logic       rescan, done;
    logic [5:0] k;
    logic [OffW-1:0] o;
    logic [OffW:0]   osum;
    mode_d = mode_q; pend_d = pend_q; line_d = line_q; col_d = col_q;
    sline_d = sline_q; scol_d = scol_q; off_d = off_q; spos_d = spos_q;
    chars_d = chars_q; len_d = len_q; frac_d = frac_q; halt_d = halt_q;
    bundle_o = '0;
    n = 3'd0;
    rescan = 1'b0;
    done = 1'b0;
    k = '0;
    o = '0;
    osum = '0;

    if (!halt_q) begin
      // Continuation of a pending token.
      unique case (mode_q)
        M_SLASH: begin
          if (c_i == "/") begin
            mode_d = M_COMMENT; done = 1'b1;
          end else begin
            bundle_o.res[n] = '{1'b0, 16'd1, 24'(spos_q), 16'(col_q), 16'(line_q),
                                E_NONE, K_SLASH};
            n = n + 3'd1; rescan = 1'b1;
          end
        end
        M_COMMENT: begin
          if (c_i == "\n") mode_d = M_IDLE;
          done = 1'b1;
        end
        M_OP: begin
          k = double_op(pend_q, c_i);
          if (k != 6'd0) begin
            mode_d = M_IDLE; done = 1'b1;
          end else if (single_op(pend_q) == 6'd0) begin
            bundle_o.res[n] = '{1'b0, 16'd1, 24'(spos_q), 16'(col_q), 16'(line_q),
                                E_UNEXPECT, 6'd0};
            n = n + 3'd1; halt_d = 1'b1; done = 1'b1; mode_d = M_IDLE;
          end else begin
            bundle_o.res[n] = '{1'b0, 16'd1, 24'(spos_q), 16'(col_q), 16'(line_q),
                                E_NONE, single_op(pend_q)};
            n = n + 3'd1; rescan = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_letter(c_i) || is_digit(c_i)) begin
            for (int i = 1; i < KwMax; i++) begin
              if (len_q == 16'(i)) chars_d[8*i +: 8] = c_i;
            end
            done = 1'b1;
          end else begin
            bundle_o.res[n] = '{1'b0, len_q, 24'(spos_q), 16'(scol_q), 16'(sline_q),
                                E_NONE, kw_kind};
            n = n + 3'd1; rescan = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit(c_i)) done = 1'b1;
          else if (c_i == "." && !frac_q) begin
            mode_d = M_NUM_DOT; done = 1'b1;
          end else if (c_i == "L" || c_i == "l" || c_i == "f" || c_i == "F" ||
                       c_i == "d" || c_i == "D") begin
            k = (c_i == "d" || c_i == "D") ? K_DBLLIT :
                ((c_i == "f" || c_i == "F" || frac_q) ? K_FLTLIT : K_LNGLIT);
            bundle_o.res[n] = '{1'b0, (len_q == 16'hFFFF) ? len_q : len_q + 16'd1,
                                24'(spos_q), 16'(scol_q), 16'(sline_q), E_NONE, k};
            n = n + 3'd1; mode_d = M_IDLE; done = 1'b1;
          end else begin
            bundle_o.res[n] = '{1'b0, len_q, 24'(spos_q), 16'(scol_q), 16'(sline_q),
                                E_NONE, frac_q ? K_FLTLIT : K_INTLIT};
            n = n + 3'd1; rescan = 1'b1;
          end
        end
        M_NUM_DOT: begin
          if (is_digit(c_i)) begin
            frac_d = 1'b1; mode_d = M_NUMBER; done = 1'b1;
          end else begin
            osum = {1'b0, spos_q} + (OffW+1)'(len_q);
            o = osum[OffW] ? OffMax : osum[OffW-1:0];
            bundle_o.res[0] = '{1'b0, len_q, 24'(spos_q), 16'(scol_q), 16'(sline_q),
                                E_NONE, K_INTLIT};
            bundle_o.res[1] = '{1'b0, 16'd1, 24'(o), 16'(col_q), 16'(line_q),
                                E_NONE, K_DOT};
            n = 3'd2; rescan = 1'b1;
          end
        end
        M_STRING: begin
          if (c_i == "\"") begin
            bundle_o.res[n] = '{1'b0, (len_q == 16'hFFFF) ? len_q : len_q + 16'd1,
                                24'(spos_q), 16'(scol_q), 16'(sline_q), E_NONE, K_STRLIT};
            n = n + 3'd1; mode_d = M_IDLE;
          end else if (c_i == "\n") begin
            bundle_o.res[n] = '{1'b0, len_q, 24'(spos_q), 16'(col_q), 16'(line_q),
                                E_UNTERM, 6'd0};
            n = n + 3'd1; halt_d = 1'b1; mode_d = M_IDLE;
          end else if (c_i == "\\") mode_d = M_ESCAPE;
          done = 1'b1;
        end
        M_ESCAPE: begin
          if (!(c_i == "n" || c_i == "t" || c_i == "r" || c_i == "\\" || c_i == "\"")) begin
            bundle_o.res[n] = '{1'b0, len_q, 24'(spos_q), 16'(col_q), 16'(line_q),
                                E_ESCAPE, 6'd0};
            n = n + 3'd1; halt_d = 1'b1; mode_d = M_IDLE;
          end else mode_d = M_STRING;
          done = 1'b1;
        end
        default: rescan = 1'b1;
      endcase

      // Position and length bookkeeping for a consumed continuation byte.
      if (done && !halt_d) begin
        off_d = (off_q < OffMax) ? off_q + 1'b1 : off_q;
        if (c_i == "\n") begin
          line_d = (line_q < PosMax) ? line_q + 1'b1 : line_q;
          col_d = PosW'(1);
        end else col_d = (col_q < PosMax) ? col_q + 1'b1 : col_q;
        // The dot of a number is counted together with the digit after it.
        if (mode_q == M_IDENT || (mode_q == M_NUMBER && is_digit(c_i)) ||
            mode_q == M_STRING || mode_q == M_ESCAPE) begin
          len_d = (len_q == 16'hFFFF) ? len_q : len_q + 16'd1;
        end
        if (mode_q == M_NUM_DOT) begin
          len_d = (len_q >= 16'hFFFE) ? 16'hFFFF : len_q + 16'd2;
        end
        if (mode_q == M_OP) begin
          bundle_o.res[n] = '{1'b0, 16'd2, 24'(spos_q), 16'(col_d), 16'(line_d),
                              E_NONE, k};
          n = n + 3'd1;
        end
      end

      // Fresh start on this byte from the idle scanner.
      if (rescan) begin
        mode_d = M_IDLE;
        off_d = (off_q < OffMax) ? off_q + 1'b1 : off_q;
        if (c_i == "\n") begin
          line_d = (line_q < PosMax) ? line_q + 1'b1 : line_q;
          col_d = PosW'(1);
        end else col_d = (col_q < PosMax) ? col_q + 1'b1 : col_q;
        if (c_i == " " || c_i == "\r" || c_i == "\t" || c_i == "\n") begin
          mode_d = M_IDLE;
        end else if (c_i == "/" || c_i == "\"" || c_i == "-" || c_i == "&" || c_i == "|" ||
                     c_i == "!" || c_i == "=" || c_i == "<" || c_i == ">" ||
                     is_letter(c_i) || is_digit(c_i)) begin
          sline_d = line_q; scol_d = col_q; spos_d = off_q;
          len_d = 16'd1; chars_d = CharW'(c_i); frac_d = 1'b0;
          if (c_i == "/") mode_d = M_SLASH;
          else if (c_i == "\"") mode_d = M_STRING;
          else if (is_letter(c_i)) mode_d = M_IDENT;
          else if (is_digit(c_i)) mode_d = M_NUMBER;
          else begin
            mode_d = M_OP; pend_d = c_i;
          end
        end else if (punct_kind(c_i) != 6'd0) begin
          bundle_o.res[n] = '{1'b0, 16'd1, 24'(off_q), 16'(col_d), 16'(line_d),
                              E_NONE, punct_kind(c_i)};
          n = n + 3'd1;
        end else begin
          bundle_o.res[n] = '{1'b0, 16'd1, 24'(off_q), 16'(col_d), 16'(line_d),
                              E_UNEXPECT, 6'd0};
          n = n + 3'd1; halt_d = 1'b1;
        end
      end

      // End of source: close whatever is pending, then EOF unless an error arose.
      if (last_i && !halt_d) begin
        unique case (mode_d)
          M_SLASH: begin
            bundle_o.res[n] = '{1'b0, 16'd1, 24'(spos_d), 16'(col_d), 16'(line_d),
                                E_NONE, K_SLASH};
            n = n + 3'd1;
          end
          M_OP: begin
            if (single_op(pend_d) == 6'd0) begin
              bundle_o.res[n] = '{1'b0, 16'd1, 24'(spos_d), 16'(col_d), 16'(line_d),
                                  E_UNEXPECT, 6'd0};
              halt_d = 1'b1;
            end else begin
              bundle_o.res[n] = '{1'b0, 16'd1, 24'(spos_d), 16'(col_d), 16'(line_d),
                                  E_NONE, single_op(pend_d)};
            end
            n = n + 3'd1;
          end
          M_IDENT: begin
            // The name includes this byte, so the lookup runs on the next-state text.
            bundle_o.res[n] = '{1'b0, len_d, 24'(spos_d), 16'(scol_d), 16'(sline_d),
                                E_NONE, ident_kind_next(chars_d, len_d)};
            n = n + 3'd1;
          end
          M_NUMBER: begin
            bundle_o.res[n] = '{1'b0, len_d, 24'(spos_d), 16'(scol_d), 16'(sline_d),
                                E_NONE, frac_d ? K_FLTLIT : K_INTLIT};
            n = n + 3'd1;
          end
          M_NUM_DOT: begin
            osum = {1'b0, spos_d} + (OffW+1)'(len_d);
            o = osum[OffW] ? OffMax : osum[OffW-1:0];
            bundle_o.res[n] = '{1'b0, len_d, 24'(spos_d), 16'(scol_d), 16'(sline_d),
                                E_NONE, K_INTLIT};
            bundle_o.res[n+3'd1] = '{1'b0, 16'd1, 24'(o), 16'(col_d), 16'(line_d),
                                     E_NONE, K_DOT};
            n = n + 3'd2;
          end
          M_STRING: begin
            bundle_o.res[n] = '{1'b0, len_d, 24'(spos_d), 16'(col_d), 16'(line_d),
                                E_UNTERM, 6'd0};
            n = n + 3'd1; halt_d = 1'b1;
          end
          M_ESCAPE: begin
            bundle_o.res[n] = '{1'b0, len_d, 24'(spos_d), 16'(col_d), 16'(line_d),
                                E_ESCAPE, 6'd0};
            n = n + 3'd1; halt_d = 1'b1;
          end
          default: ;
        endcase
        if (!halt_d) begin
          bundle_o.res[n] = '{1'b0, 16'd0, 24'(off_d), 16'(col_d), 16'(line_d),
                              E_NONE, K_EOF};
          n = n + 3'd1;
        end
      end
    end

    bundle_o.count = n;
    for (int i = 0; i < MaxResults; i++) begin
      if (n == 3'(i + 1)) bundle_o.res[i].last_result = 1'b1;
    end

    if (last_i) begin
      mode_d = M_IDLE; pend_d = '0; line_d = PosW'(1); col_d = PosW'(1);
      off_d = '0; sline_d = PosW'(1); scol_d = PosW'(1); spos_d = '0;
      chars_d = '0; len_d = '0; frac_d = 1'b0; halt_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; pend_q <= '0; line_q <= PosW'(1); col_q <= PosW'(1);
      off_q <= '0; sline_q <= PosW'(1); scol_q <= PosW'(1); spos_q <= '0;
      chars_q <= '0; len_q <= '0; frac_q <= 1'b0; halt_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d; pend_q <= pend_d; line_q <= line_d; col_q <= col_d;
      off_q <= off_d; sline_q <= sline_d; scol_q <= scol_d; spos_q <= spos_d;
      chars_q <= chars_d; len_q <= len_d; frac_q <= frac_d; halt_q <= halt_d;
    end
  end

`ifndef ASSERT_OFF
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bundle_o.count <= 3'(MaxResults)) else $error("too many results");
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |-> bundle_o.count == 3'd0) else $error("output after error");
  a_last_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> mode_q == M_IDLE && !halt_q) else $error("no reset at end");
`endif

endmodule

>>> sv/slt_queue.sv
// Short queue of result bundles between front end and output sequencer.
module slt_queue import slt_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    empty_o,
  output bundle_t data_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  bundle_t         mem_q [Depth];
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW:0]     cnt_q;

  assign full_o  = cnt_q == (AW+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

`ifndef ASSERT_OFF
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("queue underflow");
  a_nonempty_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> data_i.count != 3'd0) else $error("empty bundle queued");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import slt_pkg::*;

  // Operator and punctuation token kinds, numbered densely from the left paren.
  typedef enum logic [5:0] {
    TK_LPAREN = 6'd26, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_SEMI, TK_COMMA, TK_COLON,
    TK_DOT, TK_LBRACK, TK_RBRACK, TK_PLUS, TK_ARROW, TK_MINUS, TK_STAR, TK_SLASH,
    TK_PERCENT, TK_ANDAND, TK_AMP, TK_OROR, TK_NEQ, TK_BANG, TK_EQEQ, TK_ASSIGN,
    TK_LE, TK_LARROW, TK_LT, TK_GE, TK_GT
  } op_kind_e;

  localparam int          NO_TOKEN = -1;
  localparam int          KW_LIMIT = 6;
  localparam logic [15:0] POS_TOP  = 16'hFFFF;
  localparam logic [23:0] OFF_TOP  = 24'hFFFFFF;
  localparam logic [15:0] LEN_TOP  = 16'hFFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tlast;

  source_lexer_tokenizer dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  string kw_names[20] = '{"val", "var", "def", "if", "else", "while", "for", "return",
                          "true", "false", "void", "struct", "union", "impl", "int",
                          "long", "float", "double", "bool", "string"};

  // Tokens the scanner still owes us, oldest first.
  result_t token_q[$];
  result_t byte_tokens[$];
  int      mismatches = 0;
  bit      calm = 1'b0;

  // Scanner state mirrored by the predictor.
  logic [3:0]  mode;
  logic [7:0]  pend;
  logic [15:0] cur_line, cur_col, st_line, st_col, word_len;
  logic [23:0] cur_off, st_pos;
  logic [47:0] word_bits;
  logic        frac, halted;

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Appends one byte to the end of a source under construction.
  function automatic void put_byte(ref logic [7:0] q[$], input logic [7:0] b);
    q.insert(q.size(), b);
  endfunction

  function void clear_state();
    mode = M_IDLE; pend = '0;
    cur_line = 1; cur_col = 1; cur_off = 0;
    st_line = 1; st_col = 1; st_pos = 0;
    word_bits = '0; word_len = 0; frac = 1'b0; halted = 1'b0;
  endfunction

  function void emit(int kind, logic [1:0] err, logic [15:0] ln, logic [15:0] col,
                     logic [23:0] off, logic [15:0] len);
    result_t r;
    r.token_kind = kind[5:0];
    r.error_code = err;
    r.tok_line = ln;
    r.tok_column = col;
    r.start_offset = off;
    r.lexeme_length = len;
    r.last_result = 1'b0;
    if (byte_tokens.size() < MaxResults) byte_tokens.insert(byte_tokens.size(), r);
  endfunction

  function void tok_here(int kind, logic [23:0] off, logic [15:0] len);
    emit(kind, E_NONE, cur_line, cur_col, off, len);
  endfunction

  function void tok_start(int kind);
    emit(kind, E_NONE, st_line, st_col, st_pos, word_len);
  endfunction

  // An error is reported once; the scanner then stays quiet until tlast.
  function void raise_err(logic [1:0] code, logic [23:0] off, logic [15:0] len);
    emit(0, code, cur_line, cur_col, off, len);
    halted = 1'b1;
  endfunction

  function void consume(logic [7:0] c);
    if (cur_off < OFF_TOP) cur_off++;
    if (c == "\n") begin
      if (cur_line < POS_TOP) cur_line++;
      cur_col = 1;
    end else if (cur_col < POS_TOP) begin
      cur_col++;
    end
  endfunction

  function void lengthen();
    if (word_len < LEN_TOP) word_len++;
  endfunction

  function void begin_lexeme(logic [7:0] c);
    st_line = cur_line; st_col = cur_col; st_pos = cur_off;
    word_len = 1; word_bits = {40'd0, c}; frac = 1'b0;
  endfunction

  function int keyword_or_ident();
    bit same;
    if (word_len > KW_LIMIT) return K_IDENT;
    for (int k = 0; k < 20; k++) begin
      same = (kw_names[k].len() == word_len);
      for (int i = 0; i < kw_names[k].len() && same; i++)
        if (kw_names[k][i] != word_bits[8*i +: 8]) same = 1'b0;
      if (same) return k;
    end
    return K_IDENT;
  endfunction

  function int lone_op(logic [7:0] p);
    case (p)
      "-": return TK_MINUS;
      "&": return TK_AMP;
      "!": return TK_BANG;
      "=": return TK_ASSIGN;
      "<": return TK_LT;
      ">": return TK_GT;
      default: return NO_TOKEN;
    endcase
  endfunction

  function int paired_op(logic [7:0] p, logic [7:0] c);
    if (p == "-" && c == ">") return TK_ARROW;
    if (p == "&" && c == "&") return TK_ANDAND;
    if (p == "|" && c == "|") return TK_OROR;
    if (p == "!" && c == "=") return TK_NEQ;
    if (p == "=" && c == "=") return TK_EQEQ;
    if (p == "<" && c == "=") return TK_LE;
    if (p == "<" && c == "-") return TK_LARROW;
    if (p == ">" && c == "=") return TK_GE;
    return NO_TOKEN;
  endfunction

  function int punct_of(logic [7:0] c);
    case (c)
      "(": return TK_LPAREN;
      ")": return TK_RPAREN;
      "{": return TK_LBRACE;
      "}": return TK_RBRACE;
      ";": return TK_SEMI;
      ",": return TK_COMMA;
      ":": return TK_COLON;
      ".": return TK_DOT;
      "[": return TK_LBRACK;
      "]": return TK_RBRACK;
      "+": return TK_PLUS;
      "*": return TK_STAR;
      "%": return TK_PERCENT;
      default: return NO_TOKEN;
    endcase
  endfunction

  function void close_op();
    int k;
    k = lone_op(pend);
    if (k == NO_TOKEN) raise_err(E_UNEXPECT, st_pos, 1);
    else tok_here(k, st_pos, 1);
  endfunction

  // A number followed by a dot with no digit after it splits into two tokens.
  function void close_num_dot();
    logic [24:0] off;
    off = st_pos + word_len;
    if (off > OFF_TOP) off = OFF_TOP;
    tok_start(K_INTLIT);
    tok_here(K_DOT, off[23:0], 1);
  endfunction

  function void scan_fresh(logic [7:0] c);
    int k;
    logic [23:0] off;
    if (halted) return;
    mode = M_IDLE;
    if (c == " " || c == "\r" || c == "\t" || c == "\n") begin
      consume(c);
      return;
    end
    if (c == "/" || c == "\"") begin
      begin_lexeme(c);
      mode = (c == "/") ? M_SLASH : M_STRING;
      consume(c);
      return;
    end
    if (c == "|" || lone_op(c) != NO_TOKEN) begin
      begin_lexeme(c); pend = c; mode = M_OP; consume(c);
      return;
    end
    if (is_alpha(c) || is_num(c)) begin
      begin_lexeme(c);
      mode = is_alpha(c) ? M_IDENT : M_NUMBER;
      consume(c);
      return;
    end
    k = punct_of(c);
    off = cur_off;
    consume(c);
    if (k != NO_TOKEN) tok_here(k, off, 1);
    else raise_err(E_UNEXPECT, off, 1);
  endfunction

  function void scan_next(logic [7:0] c);
    int k;
    case (mode)
      M_SLASH: begin
        if (c == "/") begin
          mode = M_COMMENT; consume(c);
          return;
        end
        tok_here(K_SLASH, st_pos, 1);
      end
      M_COMMENT: begin
        if (c == "\n") mode = M_IDLE;
        consume(c);
        return;
      end
      M_OP: begin
        k = paired_op(pend, c);
        if (k != NO_TOKEN) begin
          consume(c); tok_here(k, st_pos, 2); mode = M_IDLE;
          return;
        end
        close_op();
        if (halted) return;
      end
      M_IDENT: begin
        if (is_alpha(c) || is_num(c)) begin
          if (word_len < KW_LIMIT) word_bits[8*word_len +: 8] = c;
          lengthen(); consume(c);
          return;
        end
        tok_start(keyword_or_ident());
      end
      M_NUMBER: begin
        if (is_num(c)) begin
          lengthen(); consume(c);
          return;
        end
        if (c == "." && !frac) begin
          mode = M_NUM_DOT; consume(c);
          return;
        end
        if (c == "L" || c == "l" || c == "f" || c == "F" || c == "d" || c == "D") begin
          if (c == "d" || c == "D") k = K_DBLLIT;
          else if (c == "f" || c == "F" || frac) k = K_FLTLIT;
          else k = K_LNGLIT;
          consume(c); lengthen(); tok_start(k); mode = M_IDLE;
          return;
        end
        tok_start(frac ? K_FLTLIT : K_INTLIT);
      end
      M_NUM_DOT: begin
        if (is_num(c)) begin
          frac = 1'b1; lengthen(); lengthen(); mode = M_NUMBER; consume(c);
          return;
        end
        close_num_dot();
      end
      M_STRING: begin
        if (c == "\"") begin
          consume(c); lengthen(); tok_start(K_STRLIT); mode = M_IDLE;
          return;
        end
        if (c == "\n") begin
          raise_err(E_UNTERM, st_pos, word_len);
          return;
        end
        if (c == "\\") mode = M_ESCAPE;
        consume(c); lengthen();
        return;
      end
      M_ESCAPE: begin
        if (c == "n" || c == "t" || c == "r" || c == "\\" || c == "\"") begin
          consume(c); lengthen(); mode = M_STRING;
          return;
        end
        raise_err(E_ESCAPE, st_pos, word_len);
        return;
      end
      default: ;
    endcase
    scan_fresh(c);
  endfunction

  function void flush_lexeme();
    case (mode)
      M_SLASH:   tok_here(K_SLASH, st_pos, 1);
      M_OP:      close_op();
      M_IDENT:   tok_start(keyword_or_ident());
      M_NUMBER:  tok_start(frac ? K_FLTLIT : K_INTLIT);
      M_NUM_DOT: close_num_dot();
      M_STRING:  raise_err(E_UNTERM, st_pos, word_len);
      M_ESCAPE:  raise_err(E_ESCAPE, st_pos, word_len);
      default: ;
    endcase
    mode = M_IDLE;
  endfunction

  // Works out the tokens one accepted byte causes and queues them.
  function void predict_tokens(logic [7:0] c, logic last);
    byte_tokens.delete();
    if (!halted) scan_next(c);
    if (last) begin
      if (!halted) begin
        flush_lexeme();
        if (!halted) tok_here(K_EOF, cur_off, 0);
      end
      clear_state();
    end
    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size()-1].last_result = 1'b1;
    foreach (byte_tokens[i]) token_q.insert(token_q.size(), byte_tokens[i]);
  endfunction

  // Sender side. Valid stays high across back-to-back bytes between idle gaps.
  task automatic idle_gap();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 19)) @(posedge clk_i);
  endtask

  task automatic send_byte(logic [7:0] c, logic last);
    if (!calm && $urandom_range(0, 7) == 0) idle_gap();
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_tokens(c, last);
  endtask

  task automatic send_bytes(logic [7:0] src[$]);
    foreach (src[i]) send_byte(src[i], i == src.size() - 1);
  endtask

  task automatic send_text(string s);
    logic [7:0] src[$];
    for (int i = 0; i < s.len(); i++) put_byte(src, s[i]);
    send_bytes(src);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (token_q.size() > 0) @(posedge clk_i);
  endtask

  function automatic void add_text(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) put_byte(q, s[i]);
  endfunction

  // Appends one lexeme (mostly well formed) to a source under construction.
  function automatic void add_lexeme(ref logic [7:0] q[$]);
    string ops[22] = '{"(", ")", "{", "}", ";", ",", ":", ".", "[", "]", "+", "*", "%",
                       "->", "&&", "||", "!=", "==", "<=", "<-", ">=", "/"};
    string singles = "-&!=<>|";
    string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string sfx = "LlfFdD";
    string esc = "ntr\\\"";
    case ($urandom_range(0, 11))
      0, 1: add_text(q, kw_names[$urandom_range(0, 19)]);
      2: begin
        put_byte(q, alnum[$urandom_range(0, 52)]);
        repeat ($urandom_range(0, 8)) put_byte(q, alnum[$urandom_range(0, 62)]);
      end
      3, 4: begin
        repeat ($urandom_range(1, 4)) put_byte(q, 8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 1)) begin
          put_byte(q, ".");
          repeat ($urandom_range(0, 3)) put_byte(q, 8'("0" + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 1)) put_byte(q, sfx[$urandom_range(0, 5)]);
      end
      5: begin
        put_byte(q, "\"");
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 3) == 0) begin
            put_byte(q, "\\");
            put_byte(q, esc[$urandom_range(0, 4)]);
          end else begin
            put_byte(q, 8'($urandom_range(8'h20, 8'hFF)));
            if (q[q.size()-1] == "\"" || q[q.size()-1] == "\\") q[q.size()-1] = "x";
          end
        end
        put_byte(q, "\"");
      end
      6, 7: add_text(q, ops[$urandom_range(0, 21)]);
      8: put_byte(q, singles[$urandom_range(0, 6)]);
      9: add_text(q, $urandom_range(0, 1) ? "// note\n" : "\n\t\r ");
      10: begin
        // Broken strings and stray bytes.
        case ($urandom_range(0, 2))
          0: add_text(q, "\"ab\n");
          1: add_text(q, "\"a\\q");
          default: put_byte(q, 8'($urandom_range(0, 255)));
        endcase
      end
      default: put_byte(q, " ");
    endcase
  endfunction

  task automatic send_random_source();
    logic [7:0] src[$];
    int target;
    target = $urandom_range(1, 30);
    while (src.size() < target) begin
      add_lexeme(src);
      if ($urandom_range(0, 1)) put_byte(src, " ");
    end
    send_bytes(src);
  endtask

  task automatic test_directed();
    logic [7:0] odd[$];
    send_text("while a1_b->c|| 9.5d<=\"\\t\\\"\"");
    send_text("4.;x/");
    send_text("\"ab\nzz");
    send_text("| q");
    send_text("a // c");
    odd = '{8'hFF, 8'h00};
    send_bytes(odd);
    send_text("\"\\q");
    send_text("\"x");
    send_text("5");
  endtask

  task automatic test_random_sources();
    for (int n = 0; n < 4; n++) send_random_source();
    // Let every token drain before the sender resumes.
    drain();
    for (int n = 0; n < 4; n++) send_random_source();
  endtask

  task automatic test_full_rate();
    calm = 1'b1;
    for (int n = 0; n < 3; n++) send_random_source();
  endtask

  // Receiver stalls in random bursts until the calm phase.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      m_axis_tready <= rst_ni;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Token word checker.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (token_q.size() == 0) begin
        $error("unexpected token word %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = token_q.pop_front();
        if (m_axis_tdata[5:0] != want.token_kind) begin
          $error("token_kind expected %0d got %0d", want.token_kind, m_axis_tdata[5:0]);
          mismatches++;
        end
        if (m_axis_tdata[7:6] != want.error_code) begin
          $error("error_code expected %0d got %0d", want.error_code, m_axis_tdata[7:6]);
          mismatches++;
        end
        if (m_axis_tdata[23:8] != want.tok_line) begin
          $error("tok_line expected %0d got %0d", want.tok_line, m_axis_tdata[23:8]);
          mismatches++;
        end
        if (m_axis_tdata[39:24] != want.tok_column) begin
          $error("tok_column expected %0d got %0d", want.tok_column, m_axis_tdata[39:24]);
          mismatches++;
        end
        if (m_axis_tdata[63:40] != want.start_offset) begin
          $error("start_offset expected %0d got %0d", want.start_offset,
                 m_axis_tdata[63:40]);
          mismatches++;
        end
        if (m_axis_tdata[79:64] != want.lexeme_length) begin
          $error("lexeme_length expected %0d got %0d", want.lexeme_length,
                 m_axis_tdata[79:64]);
          mismatches++;
        end
        if (m_axis_tlast != want.last_result) begin
          $error("last_result expected %0d got %0d", want.last_result, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    clear_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_sources();
    test_full_rate();
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && token_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
